>>> rtl/core/spd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// Widths, types and helpers shared by the segment pair distance pipeline.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int DOT_W    = 2 * DIFF_W + 2;
	localparam int PROD_W   = 2 * DOT_W;
	localparam int DIV_W    = PROD_W;
	localparam int PFRAC    = 32;
	localparam int Q_W      = PFRAC + 1;
	localparam int DIST_W   = 35;
	localparam int SQ_W     = PROD_W - 2 * PFRAC;
	localparam int MP_W     = DIFF_W + Q_W + 1;

	localparam int MUL_LAT  = 4;
	localparam int DIV_LAT  = PFRAC + 1;
	localparam int SQRT_LAT = DIST_W;
	localparam int PIPE_LAT = 11 + 3 * MUL_LAT + 2 * DIV_LAT + SQRT_LAT;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [PROD_W-1:0]  wide_t;
	typedef logic [DIV_W-1:0]          uwide_t;
	typedef logic [Q_W-1:0]            frac_t;
	typedef logic [DIST_W-1:0]         dist_t;

	localparam frac_t FRAC_ONE = {1'b1, {PFRAC{1'b0}}};

	typedef struct packed {
		diff_t d1x, d1y, d1z;
		diff_t d2x, d2y, d2z;
		diff_t rx, ry, rz;
	} geo_t;

	typedef struct packed {
		dot_t a, b, c, e, f;
	} dots_t;

	function automatic diff_t sx(input coord_t v);
		return {v[COORD_W-1], v};
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/spd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_in_if
// Segment pair input channel: valid/ready and the twelve endpoint coordinates.
// ----------------------------------------------------------------------------
interface spd_in_if;
	logic valid;
	logic ready;
	spd_pkg::coord_t seg1_start_x, seg1_start_y, seg1_start_z;
	spd_pkg::coord_t seg1_end_x, seg1_end_y, seg1_end_z;
	spd_pkg::coord_t seg2_start_x, seg2_start_y, seg2_start_z;
	spd_pkg::coord_t seg2_end_x, seg2_end_y, seg2_end_z;

	modport source (
		output valid, seg1_start_x, seg1_start_y, seg1_start_z,
		output seg1_end_x, seg1_end_y, seg1_end_z,
		output seg2_start_x, seg2_start_y, seg2_start_z,
		output seg2_end_x, seg2_end_y, seg2_end_z,
		input ready
	);
	modport sink (
		input valid, seg1_start_x, seg1_start_y, seg1_start_z,
		input seg1_end_x, seg1_end_y, seg1_end_z,
		input seg2_start_x, seg2_start_y, seg2_start_z,
		input seg2_end_x, seg2_end_y, seg2_end_z,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/core/spd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_out_if
// Distance output channel: valid/ready and the saturated distance.
// ----------------------------------------------------------------------------
interface spd_out_if;
	logic valid;
	logic ready;
	spd_pkg::dist_t distance;

	modport source (output valid, distance, input ready);
	modport sink (input valid, distance, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_mul
// Four-stage signed multiplier for dot-product sized operands, built from
// four half-width partial products.
// ----------------------------------------------------------------------------
module spd_mul (
	input  logic           clk,
	input  logic           en,
	input  spd_pkg::dot_t  x,
	input  spd_pkg::dot_t  y,
	output spd_pkg::wide_t p
);
	localparam int DW = spd_pkg::DOT_W;
	localparam int LW = DW / 2;
	localparam int PW = spd_pkg::PROD_W;

	logic          neg_s1, neg_s2, neg_s3;
	logic [DW-1:0] xm_s1, ym_s1;
	logic [2*LW-1:0] pp_s2 [4];
	logic [PW-1:0] mag_s3;
	spd_pkg::wide_t p_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= x[DW-1] ^ y[DW-1];
			xm_s1  <= x[DW-1] ? DW'(-x) : DW'(x);
			ym_s1  <= y[DW-1] ? DW'(-y) : DW'(y);

			neg_s2   <= neg_s1;
			pp_s2[0] <= xm_s1[LW-1:0]  * ym_s1[LW-1:0];
			pp_s2[1] <= xm_s1[LW-1:0]  * ym_s1[DW-1:LW];
			pp_s2[2] <= xm_s1[DW-1:LW] * ym_s1[LW-1:0];
			pp_s2[3] <= xm_s1[DW-1:LW] * ym_s1[DW-1:LW];

			neg_s3 <= neg_s2;
			mag_s3 <= PW'(pp_s2[0]) + (PW'(pp_s2[1]) << LW) + (PW'(pp_s2[2]) << LW)
				+ (PW'(pp_s2[3]) << (2 * LW));

			p_s4 <= neg_s3 ? -$signed(mag_s3) : $signed(mag_s3);
		end
	end

	assign p = p_s4;
endmodule
`default_nettype wire

>>> rtl/core/spd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_div
// Pipelined restoring divider giving clamp(num/den, 0, 1) as a fraction with
// 32 fraction bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module spd_div (
	input  logic            clk,
	input  logic            en,
	input  spd_pkg::wide_t  num,
	input  spd_pkg::uwide_t den,
	output spd_pkg::frac_t  quo
);
	localparam int W  = spd_pkg::DIV_W;
	localparam int NS = spd_pkg::PFRAC;

	typedef struct packed {
		logic         fix;
		logic         fixone;
		logic [W-1:0] rem;
		logic [NS-1:0] q;
	} dst_t;

	dst_t            st [NS+1];
	spd_pkg::uwide_t dn [NS];
	logic            num_pos;

	// Ratios at or below zero, or at or above one, skip the long division.
	assign num_pos = !num[W-1] && (num != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			st[0].fix    <= !num_pos || (W'(num) >= den);
			st[0].fixone <= num_pos && (W'(num) >= den);
			st[0].rem    <= W'(num);
			st[0].q      <= '0;
			dn[0]        <= den;
		end
	end

	for (genvar i = 1; i <= NS; i++) begin : g_step
		logic [W:0] sh;
		logic       take;

		always_comb begin
			sh   = {st[i-1].rem, 1'b0};
			take = sh >= {1'b0, dn[i-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st[i].fix    <= st[i-1].fix;
				st[i].fixone <= st[i-1].fixone;
				st[i].rem    <= take ? W'(sh - {1'b0, dn[i-1]}) : sh[W-1:0];
				st[i].q      <= {st[i-1].q[NS-2:0], take};
			end
		end

		if (i < NS) begin : g_den
			always_ff @(posedge clk) begin
				if (en) begin
					dn[i] <= dn[i-1];
				end
			end
		end
	end

	assign quo = st[NS].fix ? (st[NS].fixone ? spd_pkg::FRAC_ONE : '0)
		: {1'b0, st[NS].q};
endmodule
`default_nettype wire

>>> rtl/core/spd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_sqrt
// Pipelined integer square root, one result bit per stage, most significant
// bit first.
// ----------------------------------------------------------------------------
module spd_sqrt (
	input  logic                    clk,
	input  logic                    en,
	input  logic [spd_pkg::SQ_W-1:0] rad,
	output spd_pkg::dist_t          root
);
	localparam int SW = spd_pkg::SQ_W;
	localparam int NB = spd_pkg::DIST_W;

	logic [SW-1:0]  rem_q  [NB];
	spd_pkg::dist_t root_q [NB];

	for (genvar j = 0; j < NB; j++) begin : g_bit
		localparam int K = NB - 1 - j;
		logic [SW-1:0]  rem_in;
		spd_pkg::dist_t x_in;
		logic [SW-1:0]  trial;
		logic           take;

		if (j == 0) begin : g_first
			assign rem_in = rad;
			assign x_in   = '0;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign x_in   = root_q[j-1];
		end

		// (x + 2^K)^2 - x^2 = x*2^(K+1) + 2^(2K)
		assign trial = (SW'(x_in) << (K + 1)) + (SW'(1) << (2 * K));
		assign take  = trial <= rem_in;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= take ? rem_in - trial : rem_in;
				root_q[j] <= take ? (x_in | (spd_pkg::dist_t'(1) << K)) : x_in;
			end
		end
	end

	assign root = root_q[NB-1];
endmodule
`default_nettype wire

>>> rtl/core/segment_pair_distance_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_pair_distance_3d
// Shortest distance between two 3D segments in signed Q16.16.
// ----------------------------------------------------------------------------
// The block takes one segment pair in every cycle while the output is not
// stalled and returns the distances in order. Its pipeline is a chain of
// three restoring dividers (33 stages each, two of them side by side), three
// ranks of four-stage wide multipliers and a 35-stage square root, plus eleven
// single arithmetic stages. The whole pipeline advances together: while a
// finished distance sits at the output and is not taken, every stage holds
// and the input is not ready, even if there are bubbles inside the pipeline.
// ----------------------------------------------------------------------------
module segment_pair_distance_3d (
	input  logic clk,
	input  logic arst_n,
	spd_in_if.sink    seg_in,
	spd_out_if.source dist_out
);
	localparam int L  = spd_pkg::PIPE_LAT;
	localparam int ML = spd_pkg::MUL_LAT;
	localparam int DL = spd_pkg::DIV_LAT;
	localparam int PF = spd_pkg::PFRAC;
	localparam int DW = spd_pkg::DOT_W;
	localparam int PW = spd_pkg::PROD_W;
	localparam int MW = spd_pkg::MP_W;

	typedef logic signed [2*spd_pkg::DIFF_W-1:0] prod_t;
	typedef logic signed [MW-1:0] mprod_t;

	typedef struct packed {
		spd_pkg::dots_t dt;
		spd_pkg::geo_t  g;
	} dg_t;

	typedef struct packed {
		spd_pkg::dots_t dt;
		spd_pkg::geo_t  g;
		logic           az, ez, dz;
	} side4_t;

	typedef struct packed {
		side4_t         sd;
		spd_pkg::frac_t s0;
	} side5_t;

	typedef struct packed {
		spd_pkg::geo_t  g;
		spd_pkg::frac_t s0;
		logic           az, ez, neg, gt;
	} side7_t;

	logic         adv;
	logic [L-1:0] v_q;

	assign adv          = !v_q[L-1] || dist_out.ready;
	assign seg_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[L-2:0], seg_in.valid};
		end
	end

	// Stage 1: direction and offset vectors.
	spd_pkg::geo_t geo_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1.d1x <= spd_pkg::sx(seg_in.seg1_end_x) - spd_pkg::sx(seg_in.seg1_start_x);
			geo_s1.d1y <= spd_pkg::sx(seg_in.seg1_end_y) - spd_pkg::sx(seg_in.seg1_start_y);
			geo_s1.d1z <= spd_pkg::sx(seg_in.seg1_end_z) - spd_pkg::sx(seg_in.seg1_start_z);
			geo_s1.d2x <= spd_pkg::sx(seg_in.seg2_end_x) - spd_pkg::sx(seg_in.seg2_start_x);
			geo_s1.d2y <= spd_pkg::sx(seg_in.seg2_end_y) - spd_pkg::sx(seg_in.seg2_start_y);
			geo_s1.d2z <= spd_pkg::sx(seg_in.seg2_end_z) - spd_pkg::sx(seg_in.seg2_start_z);
			geo_s1.rx  <= spd_pkg::sx(seg_in.seg1_start_x) - spd_pkg::sx(seg_in.seg2_start_x);
			geo_s1.ry  <= spd_pkg::sx(seg_in.seg1_start_y) - spd_pkg::sx(seg_in.seg2_start_y);
			geo_s1.rz  <= spd_pkg::sx(seg_in.seg1_start_z) - spd_pkg::sx(seg_in.seg2_start_z);
		end
	end

	// Stage 2: the fifteen component products of the five dot products.
	spd_pkg::diff_t d1v [3], d2v [3], rv [3];
	prod_t          pa_s2 [3], pb_s2 [3], pc_s2 [3], pe_s2 [3], pf_s2 [3];
	spd_pkg::geo_t  geo_s2;

	assign d1v[0] = geo_s1.d1x;
	assign d1v[1] = geo_s1.d1y;
	assign d1v[2] = geo_s1.d1z;
	assign d2v[0] = geo_s1.d2x;
	assign d2v[1] = geo_s1.d2y;
	assign d2v[2] = geo_s1.d2z;
	assign rv[0]  = geo_s1.rx;
	assign rv[1]  = geo_s1.ry;
	assign rv[2]  = geo_s1.rz;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= d1v[k] * d1v[k];
				pb_s2[k] <= d1v[k] * d2v[k];
				pc_s2[k] <= d1v[k] * rv[k];
				pe_s2[k] <= d2v[k] * d2v[k];
				pf_s2[k] <= d2v[k] * rv[k];
			end
			geo_s2 <= geo_s1;
		end
	end

	// Stage 3: dot product sums.
	function automatic spd_pkg::dot_t dsum(input prod_t p0, input prod_t p1, input prod_t p2);
		return spd_pkg::dot_t'(p0) + spd_pkg::dot_t'(p1) + spd_pkg::dot_t'(p2);
	endfunction

	spd_pkg::dots_t dots_s3;
	spd_pkg::geo_t  geo_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dots_s3.a <= dsum(pa_s2[0], pa_s2[1], pa_s2[2]);
			dots_s3.b <= dsum(pb_s2[0], pb_s2[1], pb_s2[2]);
			dots_s3.c <= dsum(pc_s2[0], pc_s2[1], pc_s2[2]);
			dots_s3.e <= dsum(pe_s2[0], pe_s2[1], pe_s2[2]);
			dots_s3.f <= dsum(pf_s2[0], pf_s2[1], pf_s2[2]);
			geo_s3    <= geo_s2;
		end
	end

	// Products for the denominator and numerator of s.
	spd_pkg::wide_t ae, bb, bf, ce;
	dg_t            mside_q [ML];

	spd_mul u_mul_ae (.clk(clk), .en(adv), .x(dots_s3.a), .y(dots_s3.e), .p(ae));
	spd_mul u_mul_bb (.clk(clk), .en(adv), .x(dots_s3.b), .y(dots_s3.b), .p(bb));
	spd_mul u_mul_bf (.clk(clk), .en(adv), .x(dots_s3.b), .y(dots_s3.f), .p(bf));
	spd_mul u_mul_ce (.clk(clk), .en(adv), .x(dots_s3.c), .y(dots_s3.e), .p(ce));

	always_ff @(posedge clk) begin
		if (adv) begin
			mside_q[0] <= {dots_s3, geo_s3};
			for (int i = 1; i < ML; i++) begin
				mside_q[i] <= mside_q[i-1];
			end
		end
	end

	// Stage 4: denominator and numerator of s, degenerate flags.
	spd_pkg::wide_t  num_s4;
	spd_pkg::uwide_t den_s4;
	side4_t          sd_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4   <= bf - ce;
			den_s4   <= PW'(ae - bb);
			sd_s4.dt <= mside_q[ML-1].dt;
			sd_s4.g  <= mside_q[ML-1].g;
			sd_s4.az <= mside_q[ML-1].dt.a == '0;
			sd_s4.ez <= mside_q[ML-1].dt.e == '0;
			sd_s4.dz <= ae == bb;
		end
	end

	spd_pkg::frac_t s_div;
	side4_t         dside_q [DL];

	spd_div u_div_s (.clk(clk), .en(adv), .num(num_s4), .den(den_s4), .quo(s_div));

	always_ff @(posedge clk) begin
		if (adv) begin
			dside_q[0] <= sd_s4;
			for (int i = 1; i < DL; i++) begin
				dside_q[i] <= dside_q[i-1];
			end
		end
	end

	// Stage 5: first estimate of s; parallel or degenerate cases give zero.
	side4_t         sd_s5;
	spd_pkg::frac_t s0_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s5 <= dside_q[DL-1];
			s0_s5 <= (dside_q[DL-1].az || dside_q[DL-1].ez || dside_q[DL-1].dz) ? '0 : s_div;
		end
	end

	spd_pkg::wide_t bs;
	side5_t         bside_q [ML];

	spd_mul u_mul_bs (
		.clk(clk), .en(adv), .x(sd_s5.dt.b), .y(spd_pkg::dot_t'({1'b0, s0_s5})), .p(bs)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			bside_q[0] <= {sd_s5, s0_s5};
			for (int i = 1; i < ML; i++) begin
				bside_q[i] <= bside_q[i-1];
			end
		end
	end

	// Stage 6: numerator and denominator of t, both scaled by 2^32.
	spd_pkg::wide_t  tnum_s6;
	spd_pkg::uwide_t tden_s6;
	side5_t          sd_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			tnum_s6 <= bs + (spd_pkg::wide_t'(bside_q[ML-1].sd.dt.f) <<< PF);
			tden_s6 <= PW'(bside_q[ML-1].sd.dt.e) << PF;
			sd_s6   <= bside_q[ML-1];
		end
	end

	// Stage 7: decide whether t clamps and pick the numerator for recomputing s.
	spd_pkg::wide_t  tnum_s7, n3_s7;
	spd_pkg::uwide_t tden_s7, aden_s7;
	side7_t          sd_s7;
	logic            neg6, gt6;

	assign neg6 = tnum_s6[PW-1];
	assign gt6  = tnum_s6 > $signed(tden_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			tnum_s7   <= tnum_s6;
			tden_s7   <= tden_s6;
			aden_s7   <= PW'(sd_s6.sd.dt.a);
			n3_s7     <= (gt6 && !sd_s6.sd.ez)
				? spd_pkg::wide_t'(sd_s6.sd.dt.b) - spd_pkg::wide_t'(sd_s6.sd.dt.c)
				: -spd_pkg::wide_t'(sd_s6.sd.dt.c);
			sd_s7.g   <= sd_s6.sd.g;
			sd_s7.s0  <= sd_s6.s0;
			sd_s7.az  <= sd_s6.sd.az;
			sd_s7.ez  <= sd_s6.sd.ez;
			sd_s7.neg <= neg6;
			sd_s7.gt  <= gt6;
		end
	end

	spd_pkg::frac_t t_div, s_re;
	side7_t         tside_q [DL];

	spd_div u_div_t (.clk(clk), .en(adv), .num(tnum_s7), .den(tden_s7), .quo(t_div));
	spd_div u_div_r (.clk(clk), .en(adv), .num(n3_s7), .den(aden_s7), .quo(s_re));

	always_ff @(posedge clk) begin
		if (adv) begin
			tside_q[0] <= sd_s7;
			for (int i = 1; i < DL; i++) begin
				tside_q[i] <= tside_q[i-1];
			end
		end
	end

	// Stage 8: final s and t.
	spd_pkg::frac_t s_s8, t_s8;
	spd_pkg::geo_t  geo_s8;
	side7_t         tl;

	assign tl = tside_q[DL-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s8   <= tl.ez ? '0 : t_div;
			s_s8   <= tl.az ? '0 : ((tl.ez || tl.neg || tl.gt) ? s_re : tl.s0);
			geo_s8 <= tl.g;
		end
	end

	// Stage 9: scaled direction terms.
	spd_pkg::diff_t d1w [3], d2w [3], rw [3];
	mprod_t         m1_s9 [3], m2_s9 [3];
	spd_pkg::diff_t r_s9 [3];

	assign d1w[0] = geo_s8.d1x;
	assign d1w[1] = geo_s8.d1y;
	assign d1w[2] = geo_s8.d1z;
	assign d2w[0] = geo_s8.d2x;
	assign d2w[1] = geo_s8.d2y;
	assign d2w[2] = geo_s8.d2z;
	assign rw[0]  = geo_s8.rx;
	assign rw[1]  = geo_s8.ry;
	assign rw[2]  = geo_s8.rz;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				m1_s9[k] <= d1w[k] * $signed({1'b0, s_s8});
				m2_s9[k] <= d2w[k] * $signed({1'b0, t_s8});
				r_s9[k]  <= rw[k];
			end
		end
	end

	// Stage 10: difference of the closest points, scaled by 2^32.
	spd_pkg::dot_t dk_s10 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dk_s10[k] <= (spd_pkg::dot_t'(r_s9[k]) <<< PF) + spd_pkg::dot_t'(m1_s9[k])
					- spd_pkg::dot_t'(m2_s9[k]);
			end
		end
	end

	spd_pkg::wide_t sq0, sq1, sq2;

	spd_mul u_mul_sq0 (.clk(clk), .en(adv), .x(dk_s10[0]), .y(dk_s10[0]), .p(sq0));
	spd_mul u_mul_sq1 (.clk(clk), .en(adv), .x(dk_s10[1]), .y(dk_s10[1]), .p(sq1));
	spd_mul u_mul_sq2 (.clk(clk), .en(adv), .x(dk_s10[2]), .y(dk_s10[2]), .p(sq2));

	// Stage 11: squared length; the square root drops the 2^64 scale.
	logic [PW-1:0] sum_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s11 <= PW'(sq0 + sq1 + sq2);
		end
	end

	spd_pkg::dist_t root;

	spd_sqrt u_sqrt (.clk(clk), .en(adv), .rad(sum_s11[PW-1:2*PF]), .root(root));

	assign dist_out.valid    = v_q[L-1];
	assign dist_out.distance = root;

	// The dot product width is carried through unchanged to the multipliers.
	if (DW != 2 * spd_pkg::DIFF_W + 2) begin : g_bad_width
		assign dist_out.valid = 1'b0;
	end
endmodule
`default_nettype wire

>>> rtl/core/spd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks for the segment pair distance block, bound to its top.
// ----------------------------------------------------------------------------
module spd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input spd_pkg::dist_t distance
);
	// A held result keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("distance item dropped while stalled");

	// A held result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(distance))
		else $error("distance changed while stalled");

	// Nothing leaves the block while it is held in reset.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// With no result waiting, the pipeline always takes a new item.
	a_ready_free: assert property (@(posedge clk) !out_valid |-> in_ready)
		else $error("input stalled with empty output");
endmodule

bind segment_pair_distance_3d spd_checker u_spd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(seg_in.ready),
	.out_valid(dist_out.valid),
	.out_ready(dist_out.ready),
	.distance(dist_out.distance)
);
`default_nettype wire
